FILE: src/hashed_block_buffer_cache_unit_macros.svh
// Assertion helpers shared by the buffer cache RTL.
`ifndef HASHED_BLOCK_BUFFER_CACHE_UNIT_MACROS_SVH
`define HASHED_BLOCK_BUFFER_CACHE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HBBC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buffer cache assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HBBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buffer cache assertion failed");

`endif

FILE: src/hbbc_pkg.sv
// ----------------------------------------------------------------------------
// hbbc_pkg
// Field widths and operation and status codes of the buffer cache.
// ----------------------------------------------------------------------------
package hbbc_pkg;

   localparam int unsigned DEVICE_W = 32;
   localparam int unsigned BLOCK_W  = 32;
   localparam int unsigned SLOT_W   = 5;
   localparam int unsigned REFS_W   = 8;

   localparam logic [REFS_W-1:0] REFS_MAX = 8'hFF;

   typedef enum logic [1:0] {
      KIND_GET     = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_PIN     = 2'd2,
      KIND_UNPIN   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FREE   = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

endpackage

FILE: src/hbbc_if.sv
// ----------------------------------------------------------------------------
// hbbc_if
// Request and response channels of the buffer cache.
// ----------------------------------------------------------------------------
interface hbbc_req_if;
   logic                              valid;
   logic                              ready;
   hbbc_pkg::kind_type                kind;
   logic [hbbc_pkg::DEVICE_W-1:0]     device;
   logic [hbbc_pkg::BLOCK_W-1:0]      block_number;
   logic [hbbc_pkg::SLOT_W-1:0]       slot;

   modport source (output valid, kind, device, block_number, slot, input ready);
   modport sink   (input valid, kind, device, block_number, slot, output ready);
endinterface

interface hbbc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [hbbc_pkg::SLOT_W-1:0]       slot_out;
   logic                              hit;
   logic                              needs_fill;
   hbbc_pkg::status_type              status;

   modport source (output valid, slot_out, hit, needs_fill, status, input ready);
   modport sink   (input valid, slot_out, hit, needs_fill, status, output ready);
endinterface

FILE: src/hbbc_mod.sv
// ----------------------------------------------------------------------------
// hbbc_mod
// Remainder of a 32-bit value by the bucket count, by reciprocal multiplication.
// ----------------------------------------------------------------------------
module hbbc_mod #(
   parameter int unsigned BUCKETS = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [hbbc_pkg::BLOCK_W-1:0]      operand,
   output logic                              done,
   output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] remainder
);

   localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned SHIFT = hbbc_pkg::BLOCK_W + $clog2(BUCKETS);
   localparam int unsigned PW    = SHIFT + hbbc_pkg::BLOCK_W;
   // Rounded-up reciprocal: the bits of operand * MAGIC above SHIFT are the
   // exact quotient for every 32-bit operand.
   localparam logic [hbbc_pkg::BLOCK_W:0] MAGIC = (hbbc_pkg::BLOCK_W + 1)'(
      ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
   localparam logic [hbbc_pkg::BLOCK_W-1:0] DIVISOR = hbbc_pkg::BLOCK_W'(BUCKETS);

   typedef enum logic [1:0] {
      STEP_IDLE,
      STEP_QUOT,
      STEP_REM
   } step_type;

   step_type                       step_ff, step_in;
   logic                           done_ff, done_in;
   logic [hbbc_pkg::BLOCK_W-1:0]   op_ff, op_in;
   logic [hbbc_pkg::BLOCK_W-1:0]   quot_ff, quot_in;
   logic [BW-1:0]                  rem_ff, rem_in;
   logic [PW-1:0]                  product;
   logic [hbbc_pkg::BLOCK_W-1:0]   diff;

   assign product = PW'(op_ff) * PW'(MAGIC);
   // The quotient times the divisor never exceeds the operand, so the
   // difference is the remainder and fits in BW bits.
   assign diff    = op_ff - quot_ff * DIVISOR;

   always_comb begin
      step_in = step_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         step_in = STEP_QUOT;
         op_in   = operand;
      end else begin
         case (step_ff)
            STEP_QUOT: begin
               quot_in = product[SHIFT +: hbbc_pkg::BLOCK_W];
               step_in = STEP_REM;
            end
            STEP_REM: begin
               rem_in  = diff[BW-1:0];
               done_in = 1'b1;
               step_in = STEP_IDLE;
            end
            default: begin
               step_in = STEP_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: src/hashed_block_buffer_cache_unit.sv
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_unit
// Hashed buffer cache with recency ordering, driven by a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Carries
//   req_ch    in          kind, device, block_number, slot
//   rsp_ch    out         slot_out, hit, needs_fill, status
//
// A get passes from acceptance through the reciprocal modulo unit that finds
// the home bucket, a scan of every slot, a commit and a return to idle; its
// response is registered at the commit.  A release passes through a fetch of
// the stored block number, the modulo unit, the commit and idle; pin, unpin
// and a release of an out-of-range slot go straight to the commit and idle.
// Reset loads every slot's state at once.
// A new request transaction is accepted while a response still waits; the
// commit cycle stalls only if the response register is still occupied.
//
module hashed_block_buffer_cache_unit #(
   parameter int unsigned SLOTS   = 32,
   parameter int unsigned BUCKETS = 13
) (
   input  logic        clock,
   input  logic        reset,
   hbbc_req_if.sink    req_ch,
   hbbc_rsp_if.source  rsp_ch
);

`include "hashed_block_buffer_cache_unit_macros.svh"

   localparam int unsigned SW = $clog2(SLOTS);
   localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned CW = (SW + 1 > hbbc_pkg::SLOT_W) ? SW + 1 : hbbc_pkg::SLOT_W;
   localparam logic [BW:0]   BK = (BW + 1)'(BUCKETS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MOD,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // Per-slot state, all held in flip-flops.
   logic [hbbc_pkg::DEVICE_W-1:0] device_ff [SLOTS];
   logic [hbbc_pkg::DEVICE_W-1:0] device_in [SLOTS];
   logic [hbbc_pkg::BLOCK_W-1:0]  block_ff  [SLOTS];
   logic [hbbc_pkg::BLOCK_W-1:0]  block_in  [SLOTS];
   logic [hbbc_pkg::REFS_W-1:0]   refs_ff   [SLOTS];
   logic [hbbc_pkg::REFS_W-1:0]   refs_in   [SLOTS];
   logic                          valid_ff  [SLOTS];
   logic                          valid_in  [SLOTS];
   logic [BW-1:0]                 bucket_ff [SLOTS];
   logic [BW-1:0]                 bucket_in [SLOTS];
   logic [SW-1:0]                 rank_ff   [SLOTS];
   logic [SW-1:0]                 rank_in   [SLOTS];

   state_type                     state_ff, state_in;
   hbbc_pkg::kind_type            kind_ff, kind_in;
   logic [hbbc_pkg::DEVICE_W-1:0] dev_ff, dev_in;
   logic [hbbc_pkg::BLOCK_W-1:0]  blk_ff, blk_in;
   logic [hbbc_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic                          in_range_ff, in_range_in;
   logic [SW-1:0]                 target_ff, target_in;
   logic [BW-1:0]                 home_ff, home_in;
   logic [SW-1:0]                 idx_ff, idx_in;
   logic                          hit_found_ff, hit_found_in;
   logic [SW-1:0]                 hit_idx_ff, hit_idx_in;
   logic [SW-1:0]                 hit_rank_ff, hit_rank_in;
   logic                          free_found_ff, free_found_in;
   logic [SW-1:0]                 free_idx_ff, free_idx_in;
   logic [SW-1:0]                 free_rank_ff, free_rank_in;
   logic [BW-1:0]                 free_dist_ff, free_dist_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hbbc_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic                          rsp_fill_ff, rsp_fill_in;
   hbbc_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic                          accept;
   logic                          commit;
   logic                          mod_start;
   logic [hbbc_pkg::BLOCK_W-1:0]  mod_operand;
   logic                          mod_done;
   logic [BW-1:0]                 mod_rem;
   logic [SW-1:0]                 upd_addr;
   logic [SW-1:0]                 rd_addr;
   logic [BW-1:0]                 rd_bucket;
   logic [SW-1:0]                 rd_rank;
   logic [BW:0]                   dist_wide;
   logic [BW-1:0]                 rd_dist;
   logic                          do_front;
   logic [SW-1:0]                 front_old;

   hbbc_mod #(.BUCKETS(BUCKETS)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .operand   (mod_operand),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign accept = req_ch.valid && req_ch.ready;
   assign commit = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ch.ready);

   // On a get the granted slot is the hit if there was one, else the victim.
   assign upd_addr = (kind_ff == hbbc_pkg::KIND_GET)
                     ? (hit_found_ff ? hit_idx_ff : free_idx_ff) : target_ff;

   // A single read address serves the scan, the fetch and the commit.
   always_comb begin
      case (state_ff)
         ST_SCAN:  rd_addr = idx_ff;
         ST_FETCH: rd_addr = target_ff;
         default:  rd_addr = upd_addr;
      endcase
   end

   assign rd_bucket = bucket_ff[rd_addr];
   assign rd_rank   = rank_ff[rd_addr];

   // Distance of the slot's bucket past the home bucket, wrapping round.
   always_comb begin
      if (rd_bucket >= home_ff) dist_wide = {1'b0, rd_bucket} - {1'b0, home_ff};
      else dist_wide = {1'b0, rd_bucket} + BK - {1'b0, home_ff};
      rd_dist = dist_wide[BW-1:0];
   end

   assign mod_start   = (accept && req_ch.kind == hbbc_pkg::KIND_GET) ||
                        (state_ff == ST_FETCH);
   assign mod_operand = (state_ff == ST_FETCH) ? block_ff[rd_addr] : req_ch.block_number;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      dev_in        = dev_ff;
      blk_in        = blk_ff;
      slot_in       = slot_ff;
      in_range_in   = in_range_ff;
      target_in     = target_ff;
      home_in       = home_ff;
      idx_in        = idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_rank_in   = hit_rank_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      free_rank_in  = free_rank_ff;
      free_dist_in  = free_dist_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = (rsp_valid_ff && !rsp_ch.ready);
      do_front      = 1'b0;
      front_old     = rd_rank;
      for (int i = 0; i < SLOTS; i++) begin
         device_in[i] = device_ff[i];
         block_in[i]  = block_ff[i];
         refs_in[i]   = refs_ff[i];
         valid_in[i]  = valid_ff[i];
         bucket_in[i] = bucket_ff[i];
         rank_in[i]   = rank_ff[i];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in     = req_ch.kind;
               dev_in      = req_ch.device;
               blk_in      = req_ch.block_number;
               slot_in     = req_ch.slot;
               target_in   = SW'(req_ch.slot);
               in_range_in = (CW'(req_ch.slot) < CW'(SLOTS));
               if (req_ch.kind == hbbc_pkg::KIND_GET) state_in = ST_MOD;
               else if (req_ch.kind == hbbc_pkg::KIND_RELEASE &&
                        CW'(req_ch.slot) < CW'(SLOTS)) state_in = ST_FETCH;
               else state_in = ST_UPDATE;
            end
         end
         ST_FETCH: begin
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (mod_done) begin
               home_in       = mod_rem;
               idx_in        = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               state_in      = (kind_ff == hbbc_pkg::KIND_GET) ? ST_SCAN : ST_UPDATE;
            end
         end
         ST_SCAN: begin
            // Most recent matching slot in the home bucket.
            if (rd_bucket == home_ff && device_ff[rd_addr] == dev_ff &&
                block_ff[rd_addr] == blk_ff &&
                (!hit_found_ff || rd_rank < hit_rank_ff)) begin
               hit_found_in = 1'b1;
               hit_idx_in   = idx_ff;
               hit_rank_in  = rd_rank;
            end
            // Oldest free slot in the nearest bucket at or after home.
            if (refs_ff[rd_addr] == '0 &&
                (!free_found_ff || rd_dist < free_dist_ff ||
                 (rd_dist == free_dist_ff && rd_rank > free_rank_ff))) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
               free_rank_in  = rd_rank;
               free_dist_in  = rd_dist;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_SLOT) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = 1'b0;
               rsp_fill_in   = 1'b0;
               rsp_status_in = hbbc_pkg::STATUS_OK;
               rsp_slot_in   = slot_ff;
               if (kind_ff == hbbc_pkg::KIND_GET) begin
                  rsp_slot_in = hbbc_pkg::SLOT_W'(upd_addr);
                  if (hit_found_ff) begin
                     rsp_hit_in  = 1'b1;
                     rsp_fill_in = !valid_ff[upd_addr];
                     valid_in[upd_addr] = 1'b1;
                     if (refs_ff[upd_addr] != hbbc_pkg::REFS_MAX)
                        refs_in[upd_addr] = refs_ff[upd_addr] + 1'b1;
                  end else if (free_found_ff) begin
                     rsp_fill_in = 1'b1;
                     do_front    = (free_dist_ff != '0);
                     device_in[upd_addr] = dev_ff;
                     block_in[upd_addr]  = blk_ff;
                     valid_in[upd_addr]  = 1'b1;
                     refs_in[upd_addr]   = hbbc_pkg::REFS_W'(1);
                  end else begin
                     rsp_slot_in   = '0;
                     rsp_status_in = hbbc_pkg::STATUS_NO_FREE;
                  end
               end else if (in_range_ff) begin
                  if (kind_ff == hbbc_pkg::KIND_PIN) begin
                     if (refs_ff[upd_addr] != hbbc_pkg::REFS_MAX)
                        refs_in[upd_addr] = refs_ff[upd_addr] + 1'b1;
                  end else if (refs_ff[upd_addr] == '0) begin
                     rsp_status_in = hbbc_pkg::STATUS_UNDERFLOW;
                  end else begin
                     refs_in[upd_addr] = refs_ff[upd_addr] - 1'b1;
                     do_front = (kind_ff == hbbc_pkg::KIND_RELEASE) &&
                                (refs_ff[upd_addr] == hbbc_pkg::REFS_W'(1));
                  end
               end
               // Move the slot to the front of home_ff: every younger slot ages.
               if (do_front) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (rank_ff[i] < front_old) rank_in[i] = rank_ff[i] + 1'b1;
                  end
                  rank_in[upd_addr]   = '0;
                  bucket_in[upd_addr] = home_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            device_ff[i] <= '0;
            block_ff[i]  <= '0;
            refs_ff[i]   <= '0;
            valid_ff[i]  <= 1'b0;
            bucket_ff[i] <= BW'(i % BUCKETS);
            rank_ff[i]   <= SW'(SLOTS - 1 - i);
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < SLOTS; i++) begin
            device_ff[i] <= device_in[i];
            block_ff[i]  <= block_in[i];
            refs_ff[i]   <= refs_in[i];
            valid_ff[i]  <= valid_in[i];
            bucket_ff[i] <= bucket_in[i];
            rank_ff[i]   <= rank_in[i];
         end
      end
      kind_ff       <= kind_in;
      dev_ff        <= dev_in;
      blk_ff        <= blk_in;
      slot_ff       <= slot_in;
      in_range_ff   <= in_range_in;
      target_ff     <= target_in;
      home_ff       <= home_in;
      idx_ff        <= idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_rank_ff   <= hit_rank_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      free_rank_ff  <= free_rank_in;
      free_dist_ff  <= free_dist_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.slot_out   = rsp_slot_ff;
   assign rsp_ch.hit        = rsp_hit_ff;
   assign rsp_ch.needs_fill = rsp_fill_ff;
   assign rsp_ch.status     = rsp_status_ff;

   // The sequencer never takes a request while one is in progress.
   `HBBC_ASSERT_NOW(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_ch.ready)
   // An error response carries neither hit nor fill.
   `HBBC_ASSERT_NOW(a_error_clean, clock, reset,
      rsp_ch.valid && rsp_ch.status != hbbc_pkg::STATUS_OK,
      !rsp_ch.hit && !rsp_ch.needs_fill)
   // The end of the modulo step leads to the scan or the commit.
   `HBBC_ASSERT_NEXT(a_mod_exit, clock, reset, state_ff == ST_MOD && mod_done,
      state_ff == ST_SCAN || state_ff == ST_UPDATE)
   // A commit always leaves a response waiting.
   `HBBC_ASSERT_NEXT(a_commit_rsp, clock, reset, commit, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

FILE: sim/hashed_block_buffer_cache_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_unit_tb
// Drives gets, releases, pins and unpins into the buffer cache and compares
// every response transaction with an in-bench model of the slot pool.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache_unit_tb;

   localparam int unsigned SLOTS   = 32;
   localparam int unsigned BUCKETS = 13;
   localparam int unsigned IDLE_LIMIT = 20000;

   // One response as the cache should produce it.
   typedef struct packed {
      logic [hbbc_pkg::SLOT_W-1:0] slot_out;
      logic                        hit;
      logic                        needs_fill;
      hbbc_pkg::status_type        status;
   } cache_reply_type;

   // One directed row: the request and, where it is obvious, its reply.
   typedef struct {
      hbbc_pkg::kind_type          kind;
      logic [31:0]                 device;
      logic [31:0]                 block_number;
      logic [hbbc_pkg::SLOT_W-1:0] slot;
      bit                          typed;
      cache_reply_type             reply;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hbbc_req_if req_ch ();
   hbbc_rsp_if rsp_ch ();

   hashed_block_buffer_cache_unit #(.SLOTS(SLOTS), .BUCKETS(BUCKETS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the slot pool.
   logic [31:0]                 pool_device [SLOTS];
   logic [31:0]                 pool_block  [SLOTS];
   logic [hbbc_pkg::REFS_W-1:0] pool_refs   [SLOTS];
   logic                        pool_valid  [SLOTS];
   int unsigned                 pool_bucket [SLOTS];
   int unsigned                 pool_rank   [SLOTS];

   cache_reply_type pending_replies[$];
   int unsigned     mismatches = 0;
   int unsigned     idle_cycles = 0;
   bit              hold_off = 1'b0;
   bit              stim_done = 1'b0;

   function automatic void pool_reset();
      for (int i = 0; i < SLOTS; i++) begin
         pool_device[i] = '0;
         pool_block[i]  = '0;
         pool_refs[i]   = '0;
         pool_valid[i]  = 1'b0;
         pool_bucket[i] = i % BUCKETS;
         pool_rank[i]   = SLOTS - 1 - i;
      end
   endfunction

   // Promote a slot to most recent and move it to the given bucket.
   function automatic void promote_slot(int s, int unsigned bucket);
      int unsigned old;
      old = pool_rank[s];
      for (int i = 0; i < SLOTS; i++)
         if (pool_rank[i] < old) pool_rank[i]++;
      pool_rank[s]   = 0;
      pool_bucket[s] = bucket;
   endfunction

   function automatic int oldest_idle_slot(int unsigned bucket);
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++)
         if (pool_bucket[i] == bucket && pool_refs[i] == 0 &&
             (best < 0 || pool_rank[i] > pool_rank[best]))
            best = i;
      return best;
   endfunction

   // Applies one request to the shadow pool and returns the reply it causes.
   function automatic cache_reply_type cache_lookup(hbbc_pkg::kind_type kind,
                                                    logic [31:0] dev,
                                                    logic [31:0] blk,
                                                    logic [hbbc_pkg::SLOT_W-1:0] slot);
      cache_reply_type r;
      int unsigned     home;
      int              found;
      r = '{slot_out: slot, hit: 1'b0, needs_fill: 1'b0, status: hbbc_pkg::STATUS_OK};
      if (kind == hbbc_pkg::KIND_GET) begin
         home  = blk % BUCKETS;
         found = -1;
         for (int i = 0; i < SLOTS; i++)
            if (pool_bucket[i] == home && pool_device[i] == dev && pool_block[i] == blk &&
                (found < 0 || pool_rank[i] < pool_rank[found]))
               found = i;
         if (found >= 0) begin
            r.hit = 1'b1;
            if (pool_refs[found] != hbbc_pkg::REFS_MAX) pool_refs[found]++;
         end else begin
            found = oldest_idle_slot(home);
            // Steal from the following buckets in turn, wrapping round.
            for (int d = 1; d < BUCKETS && found < 0; d++) begin
               found = oldest_idle_slot((home + d) % BUCKETS);
               if (found >= 0) promote_slot(found, home);
            end
            if (found >= 0) begin
               pool_device[found] = dev;
               pool_block[found]  = blk;
               pool_valid[found]  = 1'b0;
               pool_refs[found]   = hbbc_pkg::REFS_W'(1);
            end
         end
         if (found < 0) begin
            r.slot_out = '0;
            r.status   = hbbc_pkg::STATUS_NO_FREE;
         end else begin
            r.slot_out   = found[hbbc_pkg::SLOT_W-1:0];
            r.needs_fill = !pool_valid[found];
            pool_valid[found] = 1'b1;
         end
      end else if (slot < SLOTS) begin
         if (kind == hbbc_pkg::KIND_PIN) begin
            if (pool_refs[slot] != hbbc_pkg::REFS_MAX) pool_refs[slot]++;
         end else if (pool_refs[slot] == 0) begin
            r.status = hbbc_pkg::STATUS_UNDERFLOW;
         end else begin
            pool_refs[slot]--;
            if (kind == hbbc_pkg::KIND_RELEASE && pool_refs[slot] == 0)
               promote_slot(slot, pool_block[slot] % BUCKETS);
         end
      end
      return r;
   endfunction

   // Offers one request transaction and holds it until it is accepted.
   // Valid stays high after acceptance; the next gap or the end of the
   // stimulus lowers it.
   task automatic send_request(hbbc_pkg::kind_type kind, logic [31:0] dev,
                               logic [31:0] blk, logic [hbbc_pkg::SLOT_W-1:0] slot);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.device       <= dev;
      req_ch.block_number <= blk;
      req_ch.slot         <= slot;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_replies.push_back(cache_lookup(kind, dev, blk, slot));
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // Directed rows; typed replies only where they follow plainly from reset.
   stim_row_type directed[$];

   initial begin
      stim_row_type       row;
      hbbc_pkg::kind_type k;
      logic [31:0]        blk;
      int unsigned        n;

      req_ch.valid = 1'b0;
      req_ch.kind = hbbc_pkg::KIND_GET;
      req_ch.device = '0;
      req_ch.block_number = '0;
      req_ch.slot = '0;
      pool_reset();

      // Get of (0, 0) hits a never-filled slot in bucket 0 after reset.
      directed.push_back('{hbbc_pkg::KIND_GET, 32'd0, 32'd0, 5'd0, 1'b1,
                           '{5'd26, 1'b1, 1'b1, hbbc_pkg::STATUS_OK}});
      // Unpin and release of an idle slot underflow.
      directed.push_back('{hbbc_pkg::KIND_UNPIN, 32'd0, 32'd0, 5'd31, 1'b1,
                           '{5'd31, 1'b0, 1'b0, hbbc_pkg::STATUS_UNDERFLOW}});
      directed.push_back('{hbbc_pkg::KIND_RELEASE, 32'd0, 32'd0, 5'd3, 1'b1,
                           '{5'd3, 1'b0, 1'b0, hbbc_pkg::STATUS_UNDERFLOW}});
      directed.push_back('{hbbc_pkg::KIND_GET, '1, '1, 5'd0, 1'b0, '0});
      directed.push_back('{hbbc_pkg::KIND_GET, '1, '1, 5'd31, 1'b0, '0});
      directed.push_back('{hbbc_pkg::KIND_PIN, 32'd0, 32'd0, 5'd31, 1'b0, '0});
      directed.push_back('{hbbc_pkg::KIND_RELEASE, 32'd0, 32'd0, 5'd31, 1'b0, '0});
      directed.push_back('{hbbc_pkg::KIND_RELEASE, '1, '1, 5'd26, 1'b0, '0});
      directed.push_back('{hbbc_pkg::KIND_GET, 32'h5a5a5a5a, 32'h80000000, 5'd17, 1'b0, '0});
      directed.push_back('{hbbc_pkg::KIND_RELEASE, '1, '1, 5'd26, 1'b0, '0});
      directed.push_back('{hbbc_pkg::KIND_PIN, 32'd0, 32'd0, 5'd0, 1'b0, '0});
      directed.push_back('{hbbc_pkg::KIND_UNPIN, 32'd0, 32'd0, 5'd0, 1'b0, '0});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         row = directed[i];
         send_request(row.kind, row.device, row.block_number, row.slot);
         if (row.typed) pending_replies[$] = row.reply;
      end

      // Fill every slot in bucket 4 to force steals, then exhaust the pool.
      for (int i = 0; i < SLOTS + 2; i++)
         send_request(hbbc_pkg::KIND_GET, 32'd7, 32'd4 + BUCKETS * i, 5'd0);
      // Push a count to saturation and back.
      repeat (260) send_request(hbbc_pkg::KIND_PIN, '0, '0, 5'd9);
      repeat (4) send_request(hbbc_pkg::KIND_UNPIN, '0, '0, 5'd9);
      for (int s = 0; s < SLOTS; s++)
         while (pool_refs[s] != 0)
            send_request(hbbc_pkg::KIND_RELEASE, '0, '0, s[hbbc_pkg::SLOT_W-1:0]);

      // Long receiver hold-off while requests keep coming.
      hold_off = 1'b1;
      repeat (30)
         send_request(hbbc_pkg::KIND_GET, $urandom_range(0, 3), $urandom_range(0, 60), '0);
      hold_off = 1'b0;

      // Random part: mostly gets over a small block range so that hits,
      // steals and a full pool all occur, with releases keeping slots moving.
      n = 0;
      while (n < 430) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: k = hbbc_pkg::KIND_GET;
            5, 6, 7:       k = hbbc_pkg::KIND_RELEASE;
            8:             k = hbbc_pkg::KIND_PIN;
            default:       k = hbbc_pkg::KIND_UNPIN;
         endcase
         blk = ($urandom_range(0, 7) == 0) ? random_word() : $urandom_range(0, 40);
         send_request(k, ($urandom_range(0, 7) == 0) ? random_word() : $urandom_range(0, 2),
                      blk, hbbc_pkg::SLOT_W'($urandom()));
         n++;
      end
      req_ch.valid <= 1'b0;

      stim_done = 1'b1;
   end

   // Receiver: random stalls, plus one long hold-off when requested.
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off && !held) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(negedge clock);
            held = 1'b1;
         end
         stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // Compares every response transaction with the oldest expected reply.
   always @(posedge clock) begin
      cache_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response with nothing expected");
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ch.slot_out !== want.slot_out || rsp_ch.hit !== want.hit ||
                rsp_ch.needs_fill !== want.needs_fill || rsp_ch.status !== want.status) begin
               mismatches++;
               // Fields in order: slot, hit, fill, status.
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           want.slot_out, want.hit, want.needs_fill, want.status,
                           rsp_ch.slot_out, rsp_ch.hit, rsp_ch.needs_fill, rsp_ch.status);
            end
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: hashed_block_buffer_cache_unit.f
+incdir+src
src/hbbc_pkg.sv
src/hbbc_if.sv
src/hbbc_mod.sv
src/hashed_block_buffer_cache_unit.sv
sim/hashed_block_buffer_cache_unit_tb.sv
